// ===== src/sofs_pkg.sv =====
package sofs_pkg;

	// fixed point formats
	localparam int FRAC_BITS   = 16;
	localparam int WORK_FRAC   = 30;
	localparam int MAX_STAGES  = 30;
	localparam int DEF_STAGES  = 16;
	localparam int NUM_MULTS   = 5;
	localparam int REG_IDX_W   = 3;
	localparam int WORD_W      = 32;
	localparam int SUM_W       = 20;
	localparam int SINE_W      = 18;
	localparam int PROD_W      = 64;
	localparam int MAG_W       = 63;
	localparam int RED_W       = 35;
	localparam int ANGLE_W     = 32;
	localparam int CORDIC_W    = 34;

	// register indexes
	localparam logic [REG_IDX_W-1:0] REG_MULT_ONE   = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_MULT_TWO   = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_MULT_THREE = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_MULT_FOUR  = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_MULT_FIVE  = 3'd4;

	// pi constants, 60 fraction bits
	localparam longint unsigned PI_Q60     = 64'h3243F6A8885A308D;
	localparam longint unsigned TWO_PI_Q60 = 64'h6487ED5110B4611A;

	function automatic longint unsigned rshift_round(longint unsigned v, int s);
		if (s == 0)
			return v;
		return (v >> s) + ((v >> (s - 1)) & 64'd1);
	endfunction

	// unsigned quotient by shift and subtract, for elaboration-time tables
	function automatic longint unsigned udiv64(longint unsigned n, longint unsigned d);
		longint unsigned q;
		longint unsigned r;
		q = 0;
		r = 0;
		for (int b = 63; b >= 0; b--) begin
			r = (r << 1) | ((n >> b) & 64'd1);
			if (r >= d) begin
				r = r - d;
				q = q | (64'd1 << b);
			end
		end
		return q;
	endfunction

	// 2*pi with 2*FRAC_BITS fraction bits
	localparam longint unsigned TP_FULL = rshift_round(TWO_PI_Q60, 60 - 2 * FRAC_BITS);
	localparam logic [RED_W-1:0] TWO_PI_P = RED_W'(TP_FULL);
	// angles at working precision
	localparam logic signed [RED_W-1:0] PI_W      = RED_W'(rshift_round(PI_Q60, 30));
	localparam logic signed [RED_W-1:0] HALF_PI_W = RED_W'(rshift_round(PI_Q60, 31));
	localparam logic signed [RED_W-1:0] TWO_PI_W  = RED_W'(rshift_round(TWO_PI_Q60, 30));

	// reduction steps: quotient bits of a 63-bit magnitude over 2*pi
	localparam int RED_STEPS  = 28;
	localparam int RED_STAGES = RED_STEPS / 2;

	// arctangent of 2^-i at 30 fraction bits, from the power series
	function automatic longint atan_q30(int i);
		longint sum;
		longint term;
		int k;
		sum = 0;
		if (i == 0)
			return longint'(rshift_round(PI_Q60 >> 2, 30));
		k = 0;
		while (i * (2 * k + 1) <= 60) begin
			term = longint'(udiv64(64'd1 << (60 - i * (2 * k + 1)), 64'(2 * k + 1)));
			sum  = ((k & 1) == 1) ? sum - term : sum + term;
			k    = k + 1;
		end
		return longint'(rshift_round(longint'(sum), 30));
	endfunction

	// cordic gain at 30 fraction bits
	function automatic longint unsigned gain_q30(int stages);
		longint unsigned k2;
		longint unsigned v;
		longint unsigned res;
		longint unsigned bt;
		k2 = 64'd1 << 60;
		for (int i = 0; i < stages && i < MAX_STAGES; i++)
			k2 = k2 - udiv64(k2, (64'd1 << (2 * i)) + 64'd1);
		v   = k2;
		res = 0;
		bt  = 64'd1 << 62;
		while (bt > v)
			bt = bt >> 2;
		while (bt != 0) begin
			if (v >= res + bt) begin
				v   = v - (res + bt);
				res = (res >> 1) + bt;
			end else begin
				res = res >> 1;
			end
			bt = bt >> 2;
		end
		return res;
	endfunction

endpackage

// ===== src/sofs_reduce.sv =====
// product of multiplier and sample, reduced modulo 2*pi and folded into [-pi/2, pi/2]
module sofs_reduce (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    in_valid,
	input  logic signed [sofs_pkg::WORD_W-1:0]      sample_x,
	input  logic signed [sofs_pkg::WORD_W-1:0]      mult,
	output logic                                    out_valid,
	output logic signed [sofs_pkg::ANGLE_W-1:0]     angle
);

	localparam int NS = sofs_pkg::RED_STAGES;

	logic signed [sofs_pkg::PROD_W-1:0] p_s1;
	logic                               v_s1;
	logic [sofs_pkg::MAG_W-1:0]         mag_s2;
	logic                               neg_s2;
	logic                               v_s2;

	logic [sofs_pkg::MAG_W-1:0] rem_s [0:NS];
	logic                       neg_s [0:NS];
	logic                       vld_s [0:NS];

	logic signed [sofs_pkg::RED_W-1:0] a_sa;
	logic                              v_sa;
	logic signed [sofs_pkg::ANGLE_W-1:0] ang_sb;
	logic                                v_sb;

	logic [sofs_pkg::RED_W-1:0]        r_fix;
	logic [sofs_pkg::RED_W-1:0]        a_round;
	logic signed [sofs_pkg::RED_W-1:0] a_wrap;
	logic signed [sofs_pkg::RED_W-1:0] a_fold;

	// one restoring step against 2*pi shifted up by j
	function automatic logic [sofs_pkg::MAG_W-1:0] mod_step(
		logic [sofs_pkg::MAG_W-1:0] r, int j);
		logic [sofs_pkg::MAG_W-1:0] d;
		d = sofs_pkg::MAG_W'(sofs_pkg::TWO_PI_P) << j;
		return (r >= d) ? r - d : r;
	endfunction

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	// product and magnitude
	always_ff @(posedge clk) begin
		p_s1   <= sofs_pkg::PROD_W'(mult) * sofs_pkg::PROD_W'(sample_x);
		neg_s2 <= p_s1[sofs_pkg::PROD_W-1];
		mag_s2 <= p_s1[sofs_pkg::PROD_W-1] ? sofs_pkg::MAG_W'(-p_s1)
		                                   : sofs_pkg::MAG_W'(p_s1);
	end

	assign rem_s[0] = mag_s2;
	assign neg_s[0] = neg_s2;
	assign vld_s[0] = v_s2;

	// two quotient bits per stage
	for (genvar g = 0; g < NS; g++) begin : g_red
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_s[g+1] <= 1'b0;
			else
				vld_s[g+1] <= vld_s[g];
		end
		always_ff @(posedge clk) begin
			rem_s[g+1] <= mod_step(mod_step(rem_s[g], sofs_pkg::RED_STEPS - 1 - 2 * g),
			                       sofs_pkg::RED_STEPS - 2 - 2 * g);
			neg_s[g+1] <= neg_s[g];
		end
	end

	// mathematical modulo for negative products, then move to 30 fraction bits
	always_comb begin
		r_fix = sofs_pkg::RED_W'(rem_s[NS]);
		if (neg_s[NS] && r_fix != '0)
			r_fix = sofs_pkg::TWO_PI_P - r_fix;
		a_round = (r_fix >> 2) + sofs_pkg::RED_W'(r_fix[1]);
	end

	// fold into [-pi/2, pi/2]
	always_comb begin
		a_wrap = (a_sa > sofs_pkg::PI_W) ? a_sa - sofs_pkg::TWO_PI_W : a_sa;
		if (a_wrap > sofs_pkg::HALF_PI_W)
			a_fold = sofs_pkg::PI_W - a_wrap;
		else if (a_wrap < -sofs_pkg::HALF_PI_W)
			a_fold = -sofs_pkg::PI_W - a_wrap;
		else
			a_fold = a_wrap;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sa <= 1'b0;
			v_sb <= 1'b0;
		end else begin
			v_sa <= vld_s[NS];
			v_sb <= v_sa;
		end
	end

	always_ff @(posedge clk) begin
		a_sa   <= a_round;
		ang_sb <= sofs_pkg::ANGLE_W'(a_fold);
	end

	assign out_valid = v_sb;
	assign angle     = ang_sb;

endmodule

// ===== src/sofs_cordic.sv =====
// rotation-mode cordic, one iteration per stage, sine rounded and clamped to +-1
module sofs_cordic #(
	parameter int CORDIC_STAGES = sofs_pkg::DEF_STAGES
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	input  logic signed [sofs_pkg::ANGLE_W-1:0]  angle,
	output logic                                 out_valid,
	output logic signed [sofs_pkg::SINE_W-1:0]   sine
);

	localparam int CW = sofs_pkg::CORDIC_W;
	localparam int SH = sofs_pkg::WORK_FRAC - sofs_pkg::FRAC_BITS;
	localparam logic signed [CW-1:0] GAIN = CW'(sofs_pkg::gain_q30(CORDIC_STAGES));
	localparam logic signed [CW-1:0] HALF = CW'(1) <<< (SH - 1);
	localparam logic signed [CW-1:0] ONE  = CW'(1) <<< sofs_pkg::FRAC_BITS;

	logic signed [CW-1:0] x_s [0:CORDIC_STAGES];
	logic signed [CW-1:0] y_s [0:CORDIC_STAGES];
	logic signed [CW-1:0] z_s [0:CORDIC_STAGES];
	logic                 v_s [0:CORDIC_STAGES];

	logic signed [CW-1:0]                s_full;
	logic signed [sofs_pkg::SINE_W-1:0]  sine_so;
	logic                                v_so;

	assign x_s[0] = GAIN;
	assign y_s[0] = '0;
	assign z_s[0] = CW'(angle);
	assign v_s[0] = in_valid;

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_iter
		localparam logic signed [CW-1:0] ATAN = CW'(sofs_pkg::atan_q30(i));
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				v_s[i+1] <= 1'b0;
			else
				v_s[i+1] <= v_s[i];
		end
		// rotate toward zero residual angle
		always_ff @(posedge clk) begin
			if (!z_s[i][CW-1]) begin
				x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] - ATAN;
			end else begin
				x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] + ATAN;
			end
		end
	end

	// round half up to output precision
	assign s_full = (y_s[CORDIC_STAGES] + HALF) >>> SH;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_so <= 1'b0;
		else
			v_so <= v_s[CORDIC_STAGES];
	end

	// clamp overshoot
	always_ff @(posedge clk) begin
		if (s_full > ONE)
			sine_so <= sofs_pkg::SINE_W'(ONE);
		else if (s_full < -ONE)
			sine_so <= sofs_pkg::SINE_W'(-ONE);
		else
			sine_so <= sofs_pkg::SINE_W'(s_full);
	end

	assign out_valid = v_so;
	assign sine      = sine_so;

endmodule

// ===== src/sum_of_five_sines_core.sv =====
// Sum of five sines: each accepted sample_x (signed Q16.16) gives one sine_sum =
// sum over k of sin(mult_k * sample_x), signed Q4.16 in [-5, +5]. The block is a
// fixed pipeline that takes a word every cycle (busy stays low) and shows each
// result with done high for exactly one cycle, in order; the receiver cannot
// stall it. Each of the five parallel lanes has one multiply stage, one
// magnitude stage, fourteen stages of modulo 2*pi reduction (two quotient bits
// each), two fold stages, one stage per cordic iteration (16 by default) and
// one rounding stage; the final adder follows. Multipliers are written through
// cfg_we, cfg_index (0 to 4, others ignored) and cfg_data; the user must write
// them only while no word is in flight; the block itself does not enforce this.
module sum_of_five_sines_core #(
	parameter int CORDIC_STAGES = sofs_pkg::DEF_STAGES
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  logic signed [sofs_pkg::WORD_W-1:0]    sample_x,
	input  logic                                  cfg_we,
	input  logic [sofs_pkg::REG_IDX_W-1:0]        cfg_index,
	input  logic [sofs_pkg::WORD_W-1:0]           cfg_data,
	output logic                                  done,
	output logic signed [sofs_pkg::SUM_W-1:0]     sine_sum
);

	localparam int NM = sofs_pkg::NUM_MULTS;

	logic signed [sofs_pkg::WORD_W-1:0]  mult_q [0:NM-1];
	logic signed [sofs_pkg::ANGLE_W-1:0] angle  [0:NM-1];
	logic signed [sofs_pkg::SINE_W-1:0]  sine   [0:NM-1];
	logic [NM-1:0]                       ang_v;
	logic [NM-1:0]                       sin_v;
	logic signed [sofs_pkg::SUM_W-1:0]   sum_so;
	logic                                v_so;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NM; k++)
				mult_q[k] <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				sofs_pkg::REG_MULT_ONE:   mult_q[0] <= cfg_data;
				sofs_pkg::REG_MULT_TWO:   mult_q[1] <= cfg_data;
				sofs_pkg::REG_MULT_THREE: mult_q[2] <= cfg_data;
				sofs_pkg::REG_MULT_FOUR:  mult_q[3] <= cfg_data;
				sofs_pkg::REG_MULT_FIVE:  mult_q[4] <= cfg_data;
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;

	// one lane per multiplier
	for (genvar k = 0; k < NM; k++) begin : g_lane
		sofs_reduce u_reduce (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (start),
			.sample_x  (sample_x),
			.mult      (mult_q[k]),
			.out_valid (ang_v[k]),
			.angle     (angle[k])
		);
		sofs_cordic #(
			.CORDIC_STAGES (CORDIC_STAGES)
		) u_cordic (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (ang_v[k]),
			.angle     (angle[k]),
			.out_valid (sin_v[k]),
			.sine      (sine[k])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_so <= 1'b0;
		else
			v_so <= sin_v[0];
	end

	// add the five sines
	always_ff @(posedge clk) begin
		sum_so <= sofs_pkg::SUM_W'(sine[0]) + sofs_pkg::SUM_W'(sine[1])
		        + sofs_pkg::SUM_W'(sine[2]) + sofs_pkg::SUM_W'(sine[3])
		        + sofs_pkg::SUM_W'(sine[4]);
	end

	assign done     = v_so;
	assign sine_sum = sum_so;

endmodule
